// File: design/fre_pkg.sv
// Shared types, constants and run encoding function for the frame RLE encoder.
// Used by fre_front, fre_queue, fre_back and frame_rle_encoder_core.
`default_nettype none
package fre_pkg;

  localparam int MAX_FRAME_BYTES = 65535;
  localparam int BURST_MAX       = 3;
  localparam int QUEUE_DEPTH     = 4;
  localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

  localparam logic [3:0] RUN_MAX = 4'd15;
  localparam logic [3:0] RUN_MIN = 4'd3;

  typedef logic [1:0] burst_cnt_t;

  typedef struct packed {
    burst_cnt_t                      cnt;
    logic [BURST_MAX-1:0][7:0]       bytes;
    logic                            frame_end;
    logic [15:0]                     frame_bytes;
  } burst_t;

  typedef struct packed {
    burst_cnt_t      cnt;
    logic [1:0][7:0] bytes;
  } run_enc_t;

  typedef struct packed {
    logic   empty;
    logic   full;
  } queue_status_t;

  function automatic run_enc_t encode_run(input logic active, input logic [3:0] len,
                                          input logic [7:0] val);
    run_enc_t r;
    r.cnt   = 2'd0;
    r.bytes = '0;
    if (active) begin
      if (len >= RUN_MIN) begin
        r.cnt      = 2'd2;
        r.bytes[0] = {4'd0, len - RUN_MIN};
        r.bytes[1] = val;
      end else if (len == 4'd2) begin
        r.cnt      = 2'd2;
        r.bytes[0] = val;
        r.bytes[1] = val;
      end else if (len == 4'd1) begin
        r.cnt      = 2'd1;
        r.bytes[0] = val;
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/fre_front.sv
// Front part: accepts pixels, tracks the open run and byte total, builds bursts.
// Depends on fre_pkg.
`default_nettype none
module fre_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_push,
  input  wire logic [7:0]     in_pixel,
  input  wire logic           in_frame_end,
  input  wire logic           cfg_valid,
  input  wire logic           cfg_data,
  input  wire logic           q_full,
  output logic                q_push,
  output fre_pkg::burst_t     q_data
);

  logic        rle_enable_r, rle_enable_nxt;
  logic        run_active_r, run_active_nxt;
  logic [7:0]  run_value_r,  run_value_nxt;
  logic [3:0]  run_length_r, run_length_nxt;
  logic [15:0] byte_total_r, byte_total_nxt;

  logic               accept;
  logic               brk;
  logic               new_active;
  logic [7:0]         new_value;
  logic [3:0]         new_length;
  fre_pkg::run_enc_t  first_enc;
  fre_pkg::run_enc_t  second_enc;
  fre_pkg::burst_cnt_t total_cnt;
  logic [16:0]        sum;
  logic [15:0]        sat_total;

  assign accept = in_push && !q_full;

  always_comb begin
    brk        = run_active_r && ((in_pixel != run_value_r) || (run_length_r >= fre_pkg::RUN_MAX));
    first_enc  = '0;
    second_enc = '0;
    new_active = run_active_r;
    new_value  = run_value_r;
    new_length = run_length_r;
    if (!rle_enable_r) begin
      first_enc           = fre_pkg::encode_run(run_active_r, run_length_r, run_value_r);
      second_enc.cnt      = 2'd1;
      second_enc.bytes[0] = in_pixel;
      new_active          = 1'b0;
      new_length          = 4'd0;
    end else begin
      if (brk) begin
        first_enc = fre_pkg::encode_run(run_active_r, run_length_r, run_value_r);
      end
      if (brk || !run_active_r) begin
        new_active = 1'b1;
        new_value  = in_pixel;
        new_length = 4'd1;
      end else begin
        new_length = run_length_r + 4'd1;
      end
      if (in_frame_end) begin
        second_enc = fre_pkg::encode_run(new_active, new_length, new_value);
        new_active = 1'b0;
        new_length = 4'd0;
      end
    end
  end

  always_comb begin
    total_cnt = first_enc.cnt + second_enc.cnt;
    q_data    = '0;
    unique case (first_enc.cnt)
      2'd0: begin
        q_data.bytes[0] = second_enc.bytes[0];
        q_data.bytes[1] = second_enc.bytes[1];
      end
      2'd1: begin
        q_data.bytes[0] = first_enc.bytes[0];
        q_data.bytes[1] = second_enc.bytes[0];
        q_data.bytes[2] = second_enc.bytes[1];
      end
      default: begin
        q_data.bytes[0] = first_enc.bytes[0];
        q_data.bytes[1] = first_enc.bytes[1];
        q_data.bytes[2] = second_enc.bytes[0];
      end
    endcase
    sum = {1'b0, byte_total_r} + {15'd0, total_cnt};
    if (sum > 17'(fre_pkg::MAX_FRAME_BYTES)) begin
      sat_total = 16'(fre_pkg::MAX_FRAME_BYTES);
    end else begin
      sat_total = sum[15:0];
    end
    q_data.cnt         = total_cnt;
    q_data.frame_end   = in_frame_end;
    q_data.frame_bytes = sat_total;
    q_push             = accept && (total_cnt != 2'd0);
  end

  always_comb begin
    rle_enable_nxt = cfg_valid ? cfg_data : rle_enable_r;
    run_active_nxt = run_active_r;
    run_value_nxt  = run_value_r;
    run_length_nxt = run_length_r;
    byte_total_nxt = byte_total_r;
    if (accept) begin
      run_active_nxt = new_active;
      run_value_nxt  = new_value;
      run_length_nxt = new_length;
      byte_total_nxt = in_frame_end ? 16'd0 : sat_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rle_enable_r <= 1'b1;
      run_active_r <= 1'b0;
      run_value_r  <= 8'd0;
      run_length_r <= 4'd0;
      byte_total_r <= 16'd0;
    end else begin
      rle_enable_r <= rle_enable_nxt;
      run_active_r <= run_active_nxt;
      run_value_r  <= run_value_nxt;
      run_length_r <= run_length_nxt;
      byte_total_r <= byte_total_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/fre_queue.sv
// Short burst queue between the front and back parts.
// Depends on fre_pkg.
`default_nettype none
module fre_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire fre_pkg::burst_t   wr_data,
  input  wire logic              pop,
  output fre_pkg::burst_t        rd_data,
  output fre_pkg::queue_status_t status
);

  fre_pkg::burst_t mem [fre_pkg::QUEUE_DEPTH];

  logic [fre_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [fre_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [fre_pkg::QPTR_W:0]   count_r,  count_nxt;
  logic                       do_push;
  logic                       do_pop;

  always_comb begin
    status.empty = (count_r == '0);
    status.full  = (count_r == (fre_pkg::QPTR_W+1)'(fre_pkg::QUEUE_DEPTH));
    do_push      = push && !status.full;
    do_pop       = pop && !status.empty;
    wr_ptr_nxt   = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt   = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt    = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  assign rd_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: design/fre_back.sv
// Back part: splits queued bursts into single result bytes behind an output register.
// Depends on fre_pkg.
`default_nettype none
module fre_back (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire fre_pkg::burst_t        q_data,
  input  wire fre_pkg::queue_status_t q_status,
  output logic                        q_pop,
  input  wire logic                   out_pop,
  output logic                        out_empty,
  output logic [7:0]                  out_byte,
  output logic                        out_burst_last,
  output logic                        out_frame_done,
  output logic [15:0]                 out_frame_bytes
);

  logic        valid_r, valid_nxt;
  logic [1:0]  idx_r,   idx_nxt;
  logic [7:0]  byte_r,  byte_nxt;
  logic        last_r,  last_nxt;
  logic        done_r,  done_nxt;
  logic [15:0] total_r, total_nxt;

  logic       load;
  logic       at_last;
  logic [7:0] sel_byte;

  always_comb begin
    case (idx_r)
      2'd0:    sel_byte = q_data.bytes[0];
      2'd1:    sel_byte = q_data.bytes[1];
      default: sel_byte = q_data.bytes[2];
    endcase
    load      = !valid_r || out_pop;
    at_last   = (idx_r == (q_data.cnt - 2'd1));
    q_pop     = load && !q_status.empty && at_last;
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    done_nxt  = done_r;
    total_nxt = total_r;
    if (load) begin
      valid_nxt = !q_status.empty;
      if (!q_status.empty) begin
        byte_nxt  = sel_byte;
        last_nxt  = at_last;
        done_nxt  = at_last && q_data.frame_end;
        total_nxt = (at_last && q_data.frame_end) ? q_data.frame_bytes : 16'd0;
        idx_nxt   = at_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r  <= byte_nxt;
    last_r  <= last_nxt;
    done_r  <= done_nxt;
    total_r <= total_nxt;
  end

  assign out_empty       = !valid_r;
  assign out_byte        = byte_r;
  assign out_burst_last  = last_r;
  assign out_frame_done  = done_r;
  assign out_frame_bytes = total_r;

endmodule
`default_nettype wire

// File: design/frame_rle_encoder_core.sv
// Frame RLE encoder top level: front part, burst queue, back part.
// Depends on fre_pkg, fre_front, fre_queue, fre_back.
// A pixel's result bytes pass through the burst queue and the back part's output register.
// Throughput: one pixel per cycle in, one result byte per cycle out while popped; a pixel causes
// 0 to 3 bytes, and the 4-entry burst queue absorbs bursts until full back-pressures the input.
// Reset (rst_n low, synchronous): RLE enabled, no open run, byte total zero, queue and output empty.
`default_nettype none
module frame_rle_encoder_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_pixel,
  input  wire logic        in_frame_end,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [7:0]       out_byte,
  output logic             out_burst_last,
  output logic             out_frame_done,
  output logic [15:0]      out_frame_bytes
);

  fre_pkg::burst_t        push_data;
  fre_pkg::burst_t        head_data;
  fre_pkg::queue_status_t q_status;
  logic                   q_push;
  logic                   q_pop;

  assign cfg_ready = 1'b1;
  assign in_full   = q_status.full;

  fre_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_pixel     (in_pixel),
    .in_frame_end (in_frame_end),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .q_full       (q_status.full),
    .q_push       (q_push),
    .q_data       (push_data)
  );

  fre_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (push_data),
    .pop     (q_pop),
    .rd_data (head_data),
    .status  (q_status)
  );

  fre_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_data          (head_data),
    .q_status        (q_status),
    .q_pop           (q_pop),
    .out_pop         (out_pop),
    .out_empty       (out_empty),
    .out_byte        (out_byte),
    .out_burst_last  (out_burst_last),
    .out_frame_done  (out_frame_done),
    .out_frame_bytes (out_frame_bytes)
  );

endmodule
`default_nettype wire
